>>> rtl/two_channel_dma_controller_assert.svh
// assertion macros shared by the checker
// no dependencies
`ifndef TWO_CHANNEL_DMA_CONTROLLER_ASSERT_SVH
`define TWO_CHANNEL_DMA_CONTROLLER_ASSERT_SVH
`define TCD_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("lbl failed");
`define TCD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lbl failed");
`endif

>>> rtl/tcdma_pkg.sv
// shared types and constants for the two-channel dma controller
// no dependencies
package tcdma_pkg;
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_REQ   = 2'd2;

  localparam logic [9:0] OFF_CLR0  = 10'h000;
  localparam logic [9:0] OFF_AL0   = 10'h002;
  localparam logic [9:0] OFF_CNT0  = 10'h004;
  localparam logic [9:0] OFF_ST0   = 10'h006;
  localparam logic [9:0] OFF_CLR1  = 10'h008;
  localparam logic [9:0] OFF_AL1   = 10'h00a;
  localparam logic [9:0] OFF_CNT1  = 10'h00c;
  localparam logic [9:0] OFF_ST1   = 10'h00e;
  localparam logic [9:0] OFF_ID0   = 10'h010;
  localparam logic [9:0] OFF_ID1   = 10'h012;
  localparam logic [9:0] OFF_DIS   = 10'h014;
  localparam logic [9:0] OFF_XAH0  = 10'h100;
  localparam logic [9:0] OFF_XAL0  = 10'h102;
  localparam logic [9:0] OFF_XCH0  = 10'h104;
  localparam logic [9:0] OFF_XCL0  = 10'h106;
  localparam logic [9:0] OFF_XCT0  = 10'h108;
  localparam logic [9:0] OFF_XST0  = 10'h10a;
  localparam logic [9:0] OFF_XAH1  = 10'h200;
  localparam logic [9:0] OFF_XAL1  = 10'h202;
  localparam logic [9:0] OFF_XCH1  = 10'h204;
  localparam logic [9:0] OFF_XCL1  = 10'h206;
  localparam logic [9:0] OFF_XCT1  = 10'h208;
  localparam logic [9:0] OFF_XST1  = 10'h20a;

  localparam logic [15:0] ID_WORD0 = 16'h3230;
  localparam logic [15:0] ID_WORD1 = 16'h4330;

  // decoded operation handed from front to back
  typedef enum logic [3:0] {
    OP_NONE, OP_READ, OP_CLEAR, OP_ADDR_HI, OP_ADDR_LO, OP_CNT_FULL,
    OP_CNT_HI, OP_CNT_LO, OP_CTL_LEGACY, OP_CTL_EXT, OP_DISARM, OP_REQ
  } op_t;

  typedef enum logic [2:0] {
    RS_ZERO, RS_ID0, RS_ID1, RS_STATUS, RS_ADDR_HI, RS_ADDR_LO, RS_CNT_HI,
    RS_CNT_LO
  } rsel_t;

  typedef struct packed {
    op_t         op;
    rsel_t       rsel;
    logic        ctl_sel;   // read of control word
    logic        ch;
    logic [15:0] data;
    logic        lvl;
  } dec_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        xfer_valid;
    logic        xfer_channel;
    logic [31:0] xfer_address;
    logic        xfer_to_device;
    logic [4:0]  irq_lines;
  } res_t;
endpackage

>>> rtl/two_channel_dma_controller.sv
// Two-channel byte DMA controller. Accepts one word per cycle while in_full
// is low (register read, register write or request line change); a word is
// decoded in the front end, waits in a two-entry queue, and is executed by
// the back end, whose single read-modify-write of the channel registers sets
// the rate of one word per clock while the result queue has room. Each word
// leaves the command queue and yields one result word in a four-entry queue.
module two_channel_dma_controller #(
  parameter int CMD_DEPTH = 2,
  parameter int RES_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_command,
  input  logic [9:0]  in_reg_offset,
  input  logic [15:0] in_write_data,
  input  logic        in_request_channel,
  input  logic        in_request_level,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_read_data,
  output logic        out_xfer_valid,
  output logic        out_xfer_channel,
  output logic [31:0] out_xfer_address,
  output logic        out_xfer_to_device,
  output logic [4:0]  out_irq_lines
);
  import tcdma_pkg::*;

  dec_t dec_in, dec_q;
  res_t res, res_q;
  logic cq_empty, rq_full, go, push_ok;

  assign push_ok = in_push && !in_full;

  tcdma_front u_front (
    .in_command, .in_reg_offset, .in_write_data, .in_request_channel,
    .in_request_level, .dec(dec_in)
  );

  tcdma_queue #(.W($bits(dec_t)), .DEPTH(CMD_DEPTH)) u_cq (
    .clk, .rst_n, .wr(push_ok), .wdata(dec_in), .rd(go), .rdata(dec_q),
    .full(in_full), .empty(cq_empty)
  );

  assign go = !cq_empty && !rq_full;

  tcdma_back u_back (.clk, .rst_n, .go, .dec(dec_q), .res);

  tcdma_queue #(.W($bits(res_t)), .DEPTH(RES_DEPTH)) u_rq (
    .clk, .rst_n, .wr(go), .wdata(res), .rd(out_pop && !out_empty),
    .rdata(res_q), .full(rq_full), .empty(out_empty)
  );

  assign out_read_data      = res_q.read_data;
  assign out_xfer_valid     = res_q.xfer_valid;
  assign out_xfer_channel   = res_q.xfer_channel;
  assign out_xfer_address   = res_q.xfer_address;
  assign out_xfer_to_device = res_q.xfer_to_device;
  assign out_irq_lines      = res_q.irq_lines;
endmodule

>>> rtl/tcdma_front.sv
// front end: decodes command and offset into an operation word
// depends on tcdma_pkg
module tcdma_front (
  input  logic [1:0]       in_command,
  input  logic [9:0]       in_reg_offset,
  input  logic [15:0]      in_write_data,
  input  logic             in_request_channel,
  input  logic             in_request_level,
  output tcdma_pkg::dec_t  dec
);
  import tcdma_pkg::*;

  always_comb begin
    dec = '0;
    dec.op = OP_NONE;
    dec.rsel = RS_ZERO;
    dec.data = in_write_data;
    dec.lvl = in_request_level;
    if (in_command == CMD_READ) begin
      dec.op = OP_READ;
      case (in_reg_offset)
        OFF_CLR0: begin dec.op = OP_CLEAR; dec.ch = 1'b0; end
        OFF_CLR1: begin dec.op = OP_CLEAR; dec.ch = 1'b1; end
        OFF_CNT0, OFF_XCL0: begin dec.rsel = RS_CNT_LO; dec.ch = 1'b0; end
        OFF_CNT1, OFF_XCL1: begin dec.rsel = RS_CNT_LO; dec.ch = 1'b1; end
        OFF_ST0, OFF_XST0: begin dec.rsel = RS_STATUS; dec.ch = 1'b0; end
        OFF_ST1, OFF_XST1: begin dec.rsel = RS_STATUS; dec.ch = 1'b1; end
        OFF_ID0: dec.rsel = RS_ID0;
        OFF_ID1: dec.rsel = RS_ID1;
        OFF_XAH0: begin dec.rsel = RS_ADDR_HI; dec.ch = 1'b0; end
        OFF_XAL0: begin dec.rsel = RS_ADDR_LO; dec.ch = 1'b0; end
        OFF_XAH1: begin dec.rsel = RS_ADDR_HI; dec.ch = 1'b1; end
        OFF_XAL1: begin dec.rsel = RS_ADDR_LO; dec.ch = 1'b1; end
        OFF_XCH0: begin dec.rsel = RS_CNT_HI; dec.ch = 1'b0; end
        OFF_XCH1: begin dec.rsel = RS_CNT_HI; dec.ch = 1'b1; end
        OFF_XCT0: begin dec.ctl_sel = 1'b1; dec.ch = 1'b0; end
        OFF_XCT1: begin dec.ctl_sel = 1'b1; dec.ch = 1'b1; end
        default: dec.rsel = RS_ZERO;
      endcase
    end else if (in_command == CMD_WRITE) begin
      case (in_reg_offset)
        OFF_CLR0, OFF_XAH0: begin dec.op = OP_ADDR_HI; dec.ch = 1'b0; end
        OFF_AL0, OFF_XAL0: begin dec.op = OP_ADDR_LO; dec.ch = 1'b0; end
        OFF_CLR1, OFF_XAH1: begin dec.op = OP_ADDR_HI; dec.ch = 1'b1; end
        OFF_AL1, OFF_XAL1: begin dec.op = OP_ADDR_LO; dec.ch = 1'b1; end
        OFF_CNT0: begin dec.op = OP_CNT_FULL; dec.ch = 1'b0; end
        OFF_CNT1: begin dec.op = OP_CNT_FULL; dec.ch = 1'b1; end
        OFF_XCH0: begin dec.op = OP_CNT_HI; dec.ch = 1'b0; end
        OFF_XCL0: begin dec.op = OP_CNT_LO; dec.ch = 1'b0; end
        OFF_XCH1: begin dec.op = OP_CNT_HI; dec.ch = 1'b1; end
        OFF_XCL1: begin dec.op = OP_CNT_LO; dec.ch = 1'b1; end
        OFF_ST0: begin dec.op = OP_CTL_LEGACY; dec.ch = 1'b0; end
        OFF_ST1: begin dec.op = OP_CTL_LEGACY; dec.ch = 1'b1; end
        OFF_XCT0: begin dec.op = OP_CTL_EXT; dec.ch = 1'b0; end
        OFF_XCT1: begin dec.op = OP_CTL_EXT; dec.ch = 1'b1; end
        OFF_DIS: dec.op = OP_DISARM;
        default: dec.op = OP_NONE;
      endcase
    end else if (in_command == CMD_REQ) begin
      dec.op = OP_REQ;
      dec.ch = in_request_channel;
    end
  end
endmodule

>>> rtl/tcdma_queue.sv
// small fifo used between front and back and for results
// depends on nothing but its parameters
module tcdma_queue #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [W-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end
endmodule

>>> rtl/tcdma_back.sv
// back end: channel register file, byte moves and irq line state
// depends on tcdma_pkg
module tcdma_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  tcdma_pkg::dec_t dec,
  output tcdma_pkg::res_t res
);
  import tcdma_pkg::*;

  logic [31:0] addr_r [2], addr_nxt [2];
  logic [31:0] cnt_r [2], cnt_nxt [2];
  logic [14:0] ctl_r [2], ctl_nxt [2];
  logic [3:0]  lvl_r [2], lvl_nxt [2];
  logic [2:0]  size_r [2], size_nxt [2];
  logic [1:0]  sub_r [2], sub_nxt [2];
  logic [1:0]  irq_r, irq_nxt, en_r, en_nxt, arm_r, arm_nxt, out_r, out_nxt;
  logic [1:0]  req_r, req_nxt;
  logic [4:0]  lines_r, lines_nxt;

  logic        c, do_move, refresh;
  logic [2:0]  sz;
  logic [15:0] rd;
  logic [4:0]  lines_calc;

  always_comb begin
    addr_nxt = addr_r; cnt_nxt = cnt_r; ctl_nxt = ctl_r; lvl_nxt = lvl_r;
    size_nxt = size_r; sub_nxt = sub_r; irq_nxt = irq_r; en_nxt = en_r;
    arm_nxt = arm_r; out_nxt = out_r; req_nxt = req_r;
    c = dec.ch;
    do_move = 1'b0;
    refresh = 1'b0;
    sz = 3'd1;
    rd = '0;
    res = '0;
    case (dec.op)
      OP_READ: begin
        if (dec.ctl_sel) rd = {1'b0, ctl_r[c]};
        else begin
          case (dec.rsel)
            RS_ID0:     rd = ID_WORD0;
            RS_ID1:     rd = ID_WORD1;
            RS_STATUS:  rd = {14'd0, irq_r[c], arm_r[c]};
            RS_ADDR_HI: rd = addr_r[c][31:16];
            RS_ADDR_LO: rd = addr_r[c][15:0];
            RS_CNT_HI:  rd = cnt_r[c][31:16];
            RS_CNT_LO:  rd = cnt_r[c][15:0];
            default:    rd = '0;
          endcase
        end
      end
      OP_CLEAR: begin
        irq_nxt[c] = 1'b0;
        arm_nxt[c] = 1'b0;
        refresh = 1'b1;
      end
      OP_ADDR_HI:  addr_nxt[c][31:16] = dec.data;
      OP_ADDR_LO:  addr_nxt[c][15:0] = dec.data;
      OP_CNT_FULL: cnt_nxt[c] = {16'd0, dec.data};
      OP_CNT_HI:   cnt_nxt[c][31:16] = dec.data;
      OP_CNT_LO:   cnt_nxt[c][15:0] = dec.data;
      OP_CTL_LEGACY, OP_CTL_EXT: begin
        ctl_nxt[c] = dec.data[14:0];
        en_nxt[c] = dec.data[0];
        out_nxt[c] = dec.data[2];
        lvl_nxt[c] = 4'd3 + {1'b0, dec.data[6:4]};
        if (dec.data[8]) sz = 3'd4;
        else if (dec.data[1]) sz = 3'd2;
        size_nxt[c] = sz;
        if (dec.data[15] || dec.op == OP_CTL_LEGACY) begin
          sub_nxt[c] = 2'(sz - 3'd1);
          arm_nxt[c] = 1'b1;
          irq_nxt[c] = 1'b0;
          do_move = req_r[c];
        end
      end
      OP_DISARM: begin
        if (dec.data[4]) arm_nxt[0] = 1'b0;
        if (dec.data[5]) arm_nxt[1] = 1'b0;
      end
      OP_REQ: begin
        req_nxt[c] = dec.lvl;
        do_move = dec.lvl;
      end
      default: ;
    endcase

    // one byte move on the selected channel
    if (do_move && arm_nxt[c]) begin
      res.xfer_valid = 1'b1;
      res.xfer_channel = c;
      res.xfer_address = addr_nxt[c];
      res.xfer_to_device = out_nxt[c];
      addr_nxt[c] = addr_nxt[c] + 32'd1;
      if (sub_nxt[c] == 2'd0) begin
        cnt_nxt[c] = cnt_nxt[c] - 32'd1;
        if (cnt_nxt[c] == 32'hffff_ffff) begin
          arm_nxt[c] = 1'b0;
          if (en_nxt[c]) begin
            irq_nxt[c] = 1'b1;
            refresh = 1'b1;
          end
        end else begin
          sub_nxt[c] = size_nxt[c][1:0] - 2'd1;
        end
      end else begin
        sub_nxt[c] = sub_nxt[c] - 2'd1;
      end
    end

    lines_calc = '0;
    for (int i = 0; i < 2; i++) begin
      if (irq_nxt[i] && en_nxt[i] && lvl_nxt[i] >= 4'd3 && lvl_nxt[i] <= 4'd7)
        lines_calc[3'(lvl_nxt[i] - 4'd3)] = 1'b1;
    end
    lines_nxt = refresh ? lines_calc : lines_r;
    res.read_data = rd;
    res.irq_lines = lines_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        addr_r[i] <= '0; cnt_r[i] <= '0; ctl_r[i] <= '0; lvl_r[i] <= '0;
        size_r[i] <= '0; sub_r[i] <= '0;
      end
      irq_r <= '0; en_r <= '0; arm_r <= '0; out_r <= '0; req_r <= '0;
      lines_r <= '0;
    end else if (go) begin
      addr_r <= addr_nxt; cnt_r <= cnt_nxt; ctl_r <= ctl_nxt; lvl_r <= lvl_nxt;
      size_r <= size_nxt; sub_r <= sub_nxt; irq_r <= irq_nxt; en_r <= en_nxt;
      arm_r <= arm_nxt; out_r <= out_nxt; req_r <= req_nxt;
      lines_r <= lines_nxt;
    end
  end
endmodule

>>> rtl/tcdma_checker.sv
// port-level checks for the dma controller, bound to the top level
// depends on two_channel_dma_controller_assert.svh
`include "two_channel_dma_controller_assert.svh"
module tcdma_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic        out_xfer_valid,
  input logic        out_xfer_channel,
  input logic [31:0] out_xfer_address,
  input logic        out_xfer_to_device
);
  `TCD_ASSERT_RST(a_reset_empty, !rst_n |=> out_empty && !in_full)
  `TCD_ASSERT_CLK(a_idle_fields, !out_empty && !out_xfer_valid |->
    !out_xfer_channel && out_xfer_address == 32'd0 && !out_xfer_to_device)
  `TCD_ASSERT_CLK(a_result_held, !out_empty && !out_pop |=> !out_empty &&
    $stable({out_xfer_valid, out_xfer_channel, out_xfer_address, out_xfer_to_device}))
endmodule

bind two_channel_dma_controller tcdma_checker u_tcdma_checker (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_xfer_valid, .out_xfer_channel,
  .out_xfer_address, .out_xfer_to_device
);
